// File: src/bprm_pkg.sv
// Package for the buffer pool rotation manager.
// Holds the slot-count constants, the command and slot status codes, and the item structs.
`timescale 1ns / 1ps
package bprm_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int SEQ_W      = 32;
    localparam int STAT_W     = 32;
    localparam int IDX_W      = 3;
    localparam int HWM_W      = 4;

    typedef enum logic [1:0] {
        CMD_GET_FREE = 2'd0,
        CMD_GET_DONE = 2'd1,
        CMD_FREE     = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        SLOT_FREE = 2'd0,
        SLOT_BUSY = 2'd1,
        SLOT_DONE = 2'd2
    } t_slot_st;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WB_OLD,
        ST_WB_NEW,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_slot_st           status;
        logic [SEQ_W-1:0]   seq;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

    typedef struct packed {
        t_cmd               command;
        logic [IDX_W-1:0]   buffer_index;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]   result_index;
        logic               result_valid;
        logic               overrun_now;
        logic [STAT_W-1:0]  gets_total;
        logic [STAT_W-1:0]  frees_total;
        logic [STAT_W-1:0]  overruns_total;
        logic [HWM_W-1:0]   completed_high_water;
    } t_out_item;

    typedef struct packed {
        logic       vld;
        t_out_item  item;
    } t_res;

endpackage

// File: src/bprm_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bprm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/bprm_ctrl.sv
// Command sequencer: scans the slot memory, writes back slot changes, keeps the counters.
// Depends on bprm_pkg and bprm_ram.
`timescale 1ns / 1ps
module bprm_ctrl import bprm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_busy,
    input  logic      i_out_free,
    output t_res      o_res
);

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_busy_fnd, n_busy_fnd;
    logic [SLOT_W-1:0]      r_busy_idx, n_busy_idx;
    logic                   r_pick_fnd, n_pick_fnd;
    logic [SLOT_W-1:0]      r_pick_idx, n_pick_idx;
    logic [HWM_W-1:0]       r_done_cnt, n_done_cnt;
    logic                   r_low_fnd, n_low_fnd;
    logic [SLOT_W-1:0]      r_low_idx, n_low_idx;
    logic [SEQ_W-1:0]       r_low_seq, n_low_seq;
    logic [SEQ_W-1:0]       r_next_seq, n_next_seq;
    logic [STAT_W-1:0]      r_gets, n_gets;
    logic [STAT_W-1:0]      r_frees, n_frees;
    logic [STAT_W-1:0]      r_ovrs, n_ovrs;
    logic [HWM_W-1:0]       r_hwm, n_hwm;
    logic [IDX_W-1:0]       r_res_idx, n_res_idx;
    logic                   r_res_valid, n_res_valid;
    logic                   r_res_ovr, n_res_ovr;
    logic [SLOT_COUNT-1:0]  r_written;
    logic                   r_rd_written;

    logic                   w_we;
    logic [SLOT_W-1:0]      w_waddr;
    t_slot                  w_wdata;
    logic                   w_re;
    logic [SLOT_W-1:0]      w_raddr;
    logic [SLOT_BITS-1:0]   w_rdata;
    t_slot                  w_entry;
    logic [SLOT_W-1:0]      w_proc_idx;
    logic                   w_res_vld;

    bprm_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_entry    = r_rd_written ? t_slot'(w_rdata) : t_slot'('0);
    assign w_proc_idx = SLOT_W'(r_cnt - CNT_W'(1));
    assign w_raddr    = r_cnt[SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_next_seq <= '0;
            r_gets     <= '0;
            r_frees    <= '0;
            r_ovrs     <= '0;
            r_hwm      <= '0;
            r_written  <= '0;
        end else begin
            r_state    <= n_state;
            r_next_seq <= n_next_seq;
            r_gets     <= n_gets;
            r_frees    <= n_frees;
            r_ovrs     <= n_ovrs;
            r_hwm      <= n_hwm;
            if (w_we) begin
                r_written[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_cnt       <= n_cnt;
        r_busy_fnd  <= n_busy_fnd;
        r_busy_idx  <= n_busy_idx;
        r_pick_fnd  <= n_pick_fnd;
        r_pick_idx  <= n_pick_idx;
        r_done_cnt  <= n_done_cnt;
        r_low_fnd   <= n_low_fnd;
        r_low_idx   <= n_low_idx;
        r_low_seq   <= n_low_seq;
        r_res_idx   <= n_res_idx;
        r_res_valid <= n_res_valid;
        r_res_ovr   <= n_res_ovr;
        if (w_re) begin
            r_rd_written <= r_written[w_raddr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_cnt       = r_cnt;
        n_busy_fnd  = r_busy_fnd;
        n_busy_idx  = r_busy_idx;
        n_pick_fnd  = r_pick_fnd;
        n_pick_idx  = r_pick_idx;
        n_done_cnt  = r_done_cnt;
        n_low_fnd   = r_low_fnd;
        n_low_idx   = r_low_idx;
        n_low_seq   = r_low_seq;
        n_next_seq  = r_next_seq;
        n_gets      = r_gets;
        n_frees     = r_frees;
        n_ovrs      = r_ovrs;
        n_hwm       = r_hwm;
        n_res_idx   = r_res_idx;
        n_res_valid = r_res_valid;
        n_res_ovr   = r_res_ovr;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = '{status: SLOT_FREE, seq: '0};
        w_re        = 1'b0;
        w_res_vld   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_cmd       = i_in_item.command;
                    n_cnt       = '0;
                    n_busy_fnd  = 1'b0;
                    n_busy_idx  = '0;
                    n_pick_fnd  = 1'b0;
                    n_pick_idx  = '0;
                    n_done_cnt  = '0;
                    n_low_fnd   = 1'b0;
                    n_low_idx   = '0;
                    n_low_seq   = '0;
                    n_res_idx   = '0;
                    n_res_valid = 1'b0;
                    n_res_ovr   = 1'b0;
                    case (i_in_item.command)
                        CMD_GET_FREE: begin
                            n_gets  = r_gets + STAT_W'(1);
                            n_state = ST_SCAN;
                        end
                        CMD_GET_DONE: begin
                            n_state = ST_SCAN;
                        end
                        CMD_FREE: begin
                            n_res_idx = i_in_item.buffer_index;
                            if (32'(i_in_item.buffer_index) < SLOT_COUNT) begin
                                w_we        = 1'b1;
                                w_waddr     = SLOT_W'(i_in_item.buffer_index);
                                n_frees     = r_frees + STAT_W'(1);
                                n_res_valid = 1'b1;
                            end
                            n_state = ST_DONE;
                        end
                        default: begin
                            n_state = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                w_re = (r_cnt < CNT_W'(SLOT_COUNT));
                if (r_cnt != '0) begin
                    if (r_cmd == CMD_GET_FREE) begin
                        case (w_entry.status)
                            SLOT_BUSY: begin
                                if (r_busy_fnd) begin
                                    w_we    = 1'b1;
                                    w_waddr = w_proc_idx;
                                end else begin
                                    n_busy_fnd = 1'b1;
                                    n_busy_idx = w_proc_idx;
                                end
                            end
                            SLOT_FREE: begin
                                n_pick_fnd = 1'b1;
                                n_pick_idx = w_proc_idx;
                            end
                            SLOT_DONE: begin
                                if (r_done_cnt != '1) begin
                                    n_done_cnt = r_done_cnt + HWM_W'(1);
                                end
                            end
                            default: begin
                            end
                        endcase
                    end else if (w_entry.status == SLOT_DONE) begin
                        if (!r_low_fnd || (w_entry.seq < r_low_seq)) begin
                            n_low_fnd = 1'b1;
                            n_low_idx = w_proc_idx;
                            n_low_seq = w_entry.seq;
                        end
                    end
                end
                if (r_cnt == CNT_W'(SLOT_COUNT)) begin
                    if (r_cmd == CMD_GET_FREE) begin
                        n_state = ST_WB_OLD;
                    end else begin
                        n_res_idx   = IDX_W'(n_low_idx);
                        n_res_valid = n_low_fnd;
                        n_state     = ST_DONE;
                    end
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end

            ST_WB_OLD: begin
                if (r_done_cnt > r_hwm) begin
                    n_hwm = r_done_cnt;
                end
                if (r_pick_fnd && r_busy_fnd) begin
                    w_we       = 1'b1;
                    w_waddr    = r_busy_idx;
                    w_wdata    = '{status: SLOT_DONE, seq: r_next_seq};
                    n_next_seq = r_next_seq + SEQ_W'(1);
                end
                n_state = ST_WB_NEW;
            end

            ST_WB_NEW: begin
                n_res_valid = 1'b1;
                if (r_pick_fnd) begin
                    w_we      = 1'b1;
                    w_waddr   = r_pick_idx;
                    w_wdata   = '{status: SLOT_BUSY, seq: '0};
                    n_res_idx = IDX_W'(r_pick_idx);
                end else begin
                    n_ovrs    = r_ovrs + STAT_W'(1);
                    n_res_ovr = 1'b1;
                    if (r_busy_fnd) begin
                        n_res_idx = IDX_W'(r_busy_idx);
                    end else begin
                        w_we      = 1'b1;
                        w_waddr   = '0;
                        w_wdata   = '{status: SLOT_BUSY, seq: '0};
                        n_res_idx = '0;
                    end
                end
                n_state = ST_DONE;
            end

            ST_DONE: begin
                if (i_out_free) begin
                    w_res_vld = 1'b1;
                    n_state   = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy    = (r_state != ST_IDLE);
    assign o_res.vld = w_res_vld;
    assign o_res.item = '{
        result_index:         r_res_idx,
        result_valid:         r_res_valid,
        overrun_now:          r_res_ovr,
        gets_total:           r_gets,
        frees_total:          r_frees,
        overruns_total:       r_ovrs,
        completed_high_water: r_hwm
    };

endmodule

// File: src/buffer_pool_rotation_manager.sv
// Top level of the buffer pool rotation manager: command sequencer plus output register.
// Depends on bprm_pkg and bprm_ctrl.
//
//  channel | direction | handshake                | payload
//  in      | input     | i_in_valid / o_in_stall  | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall| o_out_item (t_out_item)
//
// One item at a time. Get-free reads the slot memory, one slot read per cycle, then
// writes back the old busy slot and then the newly picked one, and then enters the
// result state; get-completed skips the write-back; a free or unknown command goes
// straight to the result state.
// Reset clears the counters and marks every slot free through per-slot written flags.
// A stalled result holds the sequencer in its final state; the next item waits.
`timescale 1ns / 1ps
module buffer_pool_rotation_manager import bprm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    logic       r_out_vld;
    t_out_item  r_out_item;
    logic       w_busy;
    logic       w_out_free;
    t_res       w_res;

    assign w_out_free = !r_out_vld || !i_out_stall;

    bprm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_item  (i_in_item),
        .o_busy     (w_busy),
        .i_out_free (w_out_free),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_res.vld) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res.vld) begin
            r_out_item <= w_res.item;
        end
    end

    assign o_in_stall  = w_busy;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.vld |-> w_out_free)
        else $error("result loaded over a waiting item");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second item taken while one is at work");

    a_overrun_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.overrun_now) |-> o_out_item.result_valid)
        else $error("overrun reported without a slot");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.vld |=> !o_in_stall)
        else $error("sequencer did not return to idle after a result");
`endif

endmodule

// File: bench/tb_buffer_pool_rotation_manager.sv
// Testbench for buffer_pool_rotation_manager: directed and random command traffic
// checked item by item against a slot-pool predictor kept in the bench.
// Depends on bprm_pkg and the buffer_pool_rotation_manager RTL.
`timescale 1ns / 1ps
module tb_buffer_pool_rotation_manager;
    import bprm_pkg::*;

    localparam t_cmd CMD_UNKNOWN = t_cmd'(2'b11);
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 2 * (SLOT_COUNT + 5);

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    buffer_pool_rotation_manager uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    t_slot_st          pool_status [SLOT_COUNT];
    logic [SEQ_W-1:0]  pool_seq [SLOT_COUNT];
    logic [SEQ_W-1:0]  seq_next;
    logic [STAT_W-1:0] gets_cnt;
    logic [STAT_W-1:0] frees_cnt;
    logic [STAT_W-1:0] overruns_cnt;
    logic [HWM_W-1:0]  hwm_cnt;

    t_out_item pool_expect_q [$];

    int err_count = 0;
    int results_seen = 0;
    int cycle_count = 0;
    int cmd_sent [4] = '{0, 0, 0, 0};
    int burst_left = 0;
    bit sender_gaps = 1'b0;
    int stall_mode = 0;
    int stall_run = 0;
    int stall_phase = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic void reset_pool_model();
        for (int i = 0; i < SLOT_COUNT; i++) begin
            pool_status[i] = SLOT_FREE;
            pool_seq[i] = '0;
        end
        seq_next = '0;
        gets_cnt = '0;
        frees_cnt = '0;
        overruns_cnt = '0;
        hwm_cnt = '0;
    endfunction

    function automatic t_out_item predict_pool(input t_in_item it);
        t_out_item r;
        int busy;
        int pick;
        int low;
        int unsigned done;
        r = '0;
        busy = -1;
        pick = -1;
        low = -1;
        done = 0;
        case (it.command)
            CMD_GET_FREE: begin
                gets_cnt++;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (pool_status[i] == SLOT_BUSY) begin
                        if (busy >= 0) pool_status[i] = SLOT_FREE;
                        else busy = i;
                    end else if (pool_status[i] == SLOT_FREE) begin
                        pick = i;
                    end else if (pool_status[i] == SLOT_DONE) begin
                        done++;
                    end
                end
                if (done > 15) done = 15;
                if (done > hwm_cnt) hwm_cnt = HWM_W'(done);
                r.result_valid = 1'b1;
                if (pick >= 0) begin
                    if (busy >= 0) begin
                        pool_seq[busy] = seq_next;
                        seq_next++;
                        pool_status[busy] = SLOT_DONE;
                    end
                    pool_status[pick] = SLOT_BUSY;
                    r.result_index = IDX_W'(pick);
                end else begin
                    overruns_cnt++;
                    r.overrun_now = 1'b1;
                    if (busy >= 0) begin
                        r.result_index = IDX_W'(busy);
                    end else begin
                        pool_status[0] = SLOT_BUSY;
                        r.result_index = '0;
                    end
                end
            end
            CMD_GET_DONE: begin
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (pool_status[i] == SLOT_DONE) begin
                        if (low < 0 || pool_seq[i] < pool_seq[low]) low = i;
                    end
                end
                if (low >= 0) begin
                    r.result_index = IDX_W'(low);
                    r.result_valid = 1'b1;
                end
            end
            CMD_FREE: begin
                r.result_index = it.buffer_index;
                if (int'(it.buffer_index) < SLOT_COUNT) begin
                    pool_status[it.buffer_index] = SLOT_FREE;
                    frees_cnt++;
                    r.result_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
        r.gets_total = gets_cnt;
        r.frees_total = frees_cnt;
        r.overruns_total = overruns_cnt;
        r.completed_high_water = hwm_cnt;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [STAT_W-1:0] want,
                               input logic [STAT_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pool_expect_q.size() == 0) begin
                $error("unexpected result item: result_index %0d", o_out_item.result_index);
                err_count++;
            end else begin
                want = pool_expect_q.pop_front();
                check_field("result_index", want.result_index, o_out_item.result_index);
                check_field("result_valid", want.result_valid, o_out_item.result_valid);
                check_field("overrun_now", want.overrun_now, o_out_item.overrun_now);
                check_field("gets_total", want.gets_total, o_out_item.gets_total);
                check_field("frees_total", want.frees_total, o_out_item.frees_total);
                check_field("overruns_total", want.overruns_total,
                            o_out_item.overruns_total);
                check_field("completed_high_water", want.completed_high_water,
                            o_out_item.completed_high_water);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            case (stall_mode)
                1: i_out_stall <= ($urandom_range(0, 9) < 3);
                2: begin
                    if (stall_run > 0) begin
                        stall_run <= stall_run - 1;
                        i_out_stall <= 1'b1;
                    end else if ($urandom_range(0, 5) == 0) begin
                        stall_run <= $urandom_range(1, 24);
                        i_out_stall <= 1'b1;
                    end else begin
                        i_out_stall <= 1'b0;
                    end
                end
                3: begin
                    stall_phase <= (stall_phase == 6) ? 0 : stall_phase + 1;
                    i_out_stall <= (stall_phase < 3);
                end
                default: i_out_stall <= 1'b0;
            endcase
        end
    end

    function automatic t_in_item make_item(input t_cmd cmd, input logic [IDX_W-1:0] idx);
        t_in_item it;
        it.command = cmd;
        it.buffer_index = idx;
        return it;
    endfunction

    task automatic send_item(input t_in_item it);
        int gap;
        if (sender_gaps && burst_left == 0) begin
            gap = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 6);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (!(i_in_valid && !o_in_stall)) @(posedge i_clk);
        pool_expect_q.push_back(predict_pool(it));
        cmd_sent[it.command]++;
        if (burst_left > 0) burst_left--;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pool_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_empty_pool();
        send_item(make_item(CMD_GET_DONE, 3'd0));
        send_item(make_item(CMD_UNKNOWN, 3'd7));
        send_item(make_item(CMD_FREE, 3'd5));
        send_item(make_item(CMD_UNKNOWN, 3'd0));
    endtask

    task automatic test_fill_and_overrun();
        for (int i = 0; i < SLOT_COUNT + 2; i++) send_item(make_item(CMD_GET_FREE, IDX_W'(i)));
        send_item(make_item(CMD_GET_DONE, 3'd7));
    endtask

    task automatic test_free_and_reuse();
        send_item(make_item(CMD_FREE, 3'd7));
        send_item(make_item(CMD_FREE, 3'd0));
        send_item(make_item(CMD_GET_DONE, 3'd2));
        send_item(make_item(CMD_GET_FREE, 3'd0));
        send_item(make_item(CMD_GET_FREE, 3'd0));
        send_item(make_item(CMD_FREE, 3'd3));
        send_item(make_item(CMD_FREE, 3'd3));
        send_item(make_item(CMD_GET_DONE, 3'd0));
    endtask

    task automatic test_random_traffic(input int count, input bit gaps, input int smode);
        int pct;
        t_cmd cmd;
        sender_gaps = gaps;
        stall_mode = smode;
        for (int n = 0; n < count; n++) begin
            pct = $urandom_range(0, 99);
            if (pct < 45) cmd = CMD_GET_FREE;
            else if (pct < 65) cmd = CMD_GET_DONE;
            else if (pct < 94) cmd = CMD_FREE;
            else cmd = CMD_UNKNOWN;
            send_item(make_item(cmd, IDX_W'($urandom_range(0, SLOT_COUNT - 1))));
        end
    endtask

    initial begin
        reset_pool_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_gaps = 1'b1;
        stall_mode = 1;
        test_empty_pool();
        test_fill_and_overrun();
        test_free_and_reuse();
        test_random_traffic(500, 1'b1, 1);
        test_random_traffic(400, 1'b0, 0);
        test_random_traffic(450, 1'b1, 2);
        test_random_traffic(500, 1'b1, 3);
        wait_drained();

        $display("Sent %0d get-free, %0d get-completed, %0d free, %0d unknown commands",
                 cmd_sent[CMD_GET_FREE], cmd_sent[CMD_GET_DONE], cmd_sent[CMD_FREE],
                 cmd_sent[CMD_UNKNOWN]);
        $display("Checked %0d result items, %0d overruns, high-water %0d, %0d errors",
                 results_seen, overruns_cnt, hwm_cnt, err_count);
        if (err_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
